// ----- hdl/circular_deque_push_front_back_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef CIRCULAR_DEQUE_PUSH_FRONT_BACK_MACROS_SVH
`define CIRCULAR_DEQUE_PUSH_FRONT_BACK_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CDQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is held.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("check failed: next-cycle rule");

`endif

// ----- hdl/cdq_pkg.sv -----
`timescale 1ns / 1ps

package cdq_pkg;

  // Buffer geometry
  localparam int DEPTH  = 8;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH_TAIL = 2'd0,
    OP_PUSH_HEAD = 2'd1,
    OP_POP_HEAD  = 2'd2,
    OP_LIST      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Classified command as held in the queue
  typedef struct packed {
    logic                     push;
    logic                     at_head;
    logic                     pop;
    logic                     list;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(DEPTH - 1)) r = '0;
    else r = i + 1'b1;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == '0) r = IDX_W'(DEPTH - 1);
    else r = i - 1'b1;
    return r;
  endfunction

endpackage

// ----- hdl/cdq_if.sv -----
`timescale 1ns / 1ps

// Input channel: opcode plus value
interface cdq_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic signed [cdq_pkg::DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

// Result channel: status, data, last
interface cdq_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic signed [cdq_pkg::DATA_W-1:0] data;
  logic                              last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

// ----- hdl/cdq_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/cdq_front.sv -----
`timescale 1ns / 1ps

// Front end: accepts items, decodes the opcode, queues commands
module cdq_front (
  input  logic             clk,
  input  logic             rst_n,
  cdq_in_if.sink           in_ch,
  output cdq_pkg::qhead_t  q_head,
  input  logic             q_pop
);

  cdq_pkg::cmd_t                  q_mem_r [cdq_pkg::Q_DEPTH];
  logic [cdq_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [cdq_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [cdq_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;
  cdq_pkg::cmd_t                  dec;
  logic                           push_q;

  // Decode opcode into command flags
  always_comb begin
    dec         = '0;
    dec.value   = in_ch.value;
    case (cdq_pkg::op_t'(in_ch.opcode))
      cdq_pkg::OP_PUSH_TAIL: dec.push = 1'b1;
      cdq_pkg::OP_PUSH_HEAD: begin
        dec.push    = 1'b1;
        dec.at_head = 1'b1;
      end
      cdq_pkg::OP_POP_HEAD:  dec.pop  = 1'b1;
      cdq_pkg::OP_LIST:      dec.list = 1'b1;
      default:               dec.list = 1'b1;
    endcase
  end

  assign in_ch.ready  = (cnt_r != cdq_pkg::Q_CNT_W'(cdq_pkg::Q_DEPTH));
  assign push_q       = in_ch.valid && in_ch.ready;
  assign q_head.valid = (cnt_r != '0);
  assign q_head.cmd   = q_mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_q) begin
      wr_ptr_nxt = (wr_ptr_r == cdq_pkg::Q_PTR_W'(cdq_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == cdq_pkg::Q_PTR_W'(cdq_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_q && !q_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push_q && q_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage, no reset
  always_ff @(posedge clk) begin
    if (push_q) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ----- hdl/cdq_back.sv -----
`timescale 1ns / 1ps

// Back end: owns the ring state and slot RAM, produces results
module cdq_back (
  input  logic             clk,
  input  logic             rst_n,
  input  cdq_pkg::qhead_t  q_head,
  output logic             q_pop,
  cdq_out_if.source        out_ch
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                          state_r, state_nxt;
  logic [cdq_pkg::IDX_W-1:0]       head_r, head_nxt;
  logic [cdq_pkg::IDX_W-1:0]       tail_r, tail_nxt;
  logic [cdq_pkg::CNT_W-1:0]       occ_r, occ_nxt;
  logic [cdq_pkg::IDX_W-1:0]       walk_r, walk_nxt;
  logic [cdq_pkg::IDX_W-1:0]       rem_r, rem_nxt;
  logic                            list_r, list_nxt;
  logic [cdq_pkg::CNT_W-1:0]       occ_m1;

  logic                            out_valid_r, out_valid_nxt;
  cdq_pkg::status_t                status_r, status_nxt;
  logic signed [cdq_pkg::DATA_W-1:0] data_r, data_nxt;
  logic                            last_r, last_nxt;

  logic                            ram_we, ram_re;
  logic [cdq_pkg::IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [cdq_pkg::DATA_W-1:0]      ram_rdata;
  logic                            out_free;
  cdq_pkg::cmd_t                   cmd;

  cdq_ram #(
    .WIDTH (cdq_pkg::DATA_W),
    .DEPTH (cdq_pkg::DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign cmd      = q_head.cmd;
  assign occ_m1   = occ_r - 1'b1;

  // Command execution and list walk
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    walk_nxt      = walk_r;
    rem_nxt       = rem_r;
    list_nxt      = list_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = '0;
    ram_raddr     = head_r;
    q_pop         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_head.valid && out_free) begin
          q_pop = 1'b1;
          if (cmd.push) begin
            out_valid_nxt = 1'b1;
            data_nxt      = cmd.value;
            last_nxt      = 1'b1;
            if (occ_r == cdq_pkg::CNT_W'(cdq_pkg::DEPTH)) begin
              status_nxt = cdq_pkg::ST_FULL;
            end else begin
              status_nxt = cdq_pkg::ST_OK;
              ram_we     = 1'b1;
              occ_nxt    = occ_r + 1'b1;
              if (occ_r == '0) begin
                // first entry always lands in slot zero
                head_nxt  = '0;
                tail_nxt  = '0;
                ram_waddr = '0;
              end else if (cmd.at_head) begin
                head_nxt  = cdq_pkg::idx_prev(head_r);
                ram_waddr = head_nxt;
              end else begin
                tail_nxt  = cdq_pkg::idx_next(tail_r);
                ram_waddr = tail_nxt;
              end
            end
          end else if (occ_r == '0) begin
            out_valid_nxt = 1'b1;
            status_nxt    = cdq_pkg::ST_EMPTY;
            data_nxt      = '0;
            last_nxt      = 1'b1;
          end else if (cmd.pop) begin
            ram_re    = 1'b1;
            ram_raddr = head_r;
            occ_nxt   = occ_m1;
            list_nxt  = 1'b0;
            state_nxt = S_READ;
            if (occ_m1 == '0) begin
              head_nxt = '0;
              tail_nxt = '0;
            end else begin
              head_nxt = cdq_pkg::idx_next(head_r);
            end
          end else begin
            ram_re    = 1'b1;
            ram_raddr = head_r;
            walk_nxt  = cdq_pkg::idx_next(head_r);
            rem_nxt   = occ_m1[cdq_pkg::IDX_W-1:0];
            list_nxt  = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = cdq_pkg::ST_OK;
          data_nxt      = ram_rdata;
          last_nxt      = !list_r || (rem_r == '0);
          if (list_r && (rem_r != '0)) begin
            // fetch the next entry while this one is shown
            ram_re    = 1'b1;
            ram_raddr = walk_r;
            walk_nxt  = cdq_pkg::idx_next(walk_r);
            rem_nxt   = rem_r - 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      walk_r      <= '0;
      rem_r       <= '0;
      list_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      walk_r      <= walk_nxt;
      rem_r       <= rem_nxt;
      list_r      <= list_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload, no reset
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    data_r   <= data_nxt;
    last_r   <= last_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = status_r;
  assign out_ch.data   = data_r;
  assign out_ch.last   = last_r;

endmodule

// ----- hdl/circular_deque_push_front_back.sv -----
// Push or refused/empty item: command queue, then result registers; pop adds the
// registered slot RAM read. Pushes: one item per cycle while the output is free;
// a pop holds the read state before the next command; a list gives one result per
// cycle after the first RAM read, output free. A 2-entry command queue decouples
// input acceptance from execution. Reset (rst_n low, synchronous): queue empty,
// head/tail/occupancy zero, no result pending; slot contents undefined until written.
`timescale 1ns / 1ps

module circular_deque_push_front_back (
  input  logic       clk,
  input  logic       rst_n,
  cdq_in_if.sink     in_ch,
  cdq_out_if.source  out_ch
);

  cdq_pkg::qhead_t q_head;
  logic            q_pop;

  cdq_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  cdq_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ----- hdl/cdq_checker.sv -----
`timescale 1ns / 1ps
`include "circular_deque_push_front_back_macros.svh"

// Port-level checks on the result channel
module cdq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        out_status,
  input logic signed [cdq_pkg::DATA_W-1:0] out_data,
  input logic                              out_last
);

  // stalled result holds
  `CDQ_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data) && $stable(out_status) && $stable(out_last))

  // only defined status codes appear
  `CDQ_ASSERT_IMPLY(a_status, clk, rst_n, out_valid, out_status == cdq_pkg::ST_OK || out_status == cdq_pkg::ST_FULL || out_status == cdq_pkg::ST_EMPTY)

  // refusals and empty reports are single results
  `CDQ_ASSERT_IMPLY(a_err_last, clk, rst_n, out_valid && out_status != cdq_pkg::ST_OK, out_last)

  // empty report carries zero data
  `CDQ_ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_valid && out_status == cdq_pkg::ST_EMPTY, out_data == '0)

endmodule

bind circular_deque_push_front_back cdq_checker u_cdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_data   (out_ch.data),
  .out_last   (out_ch.last)
);
